/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle property failed.");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle property failed.");

`endif

/* rtl/its_pkg.sv */
// ---------------------------------------------------------------------------
// its_pkg
// Types, constants and helpers shared by the interval timer slot table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package its_pkg;

    localparam int SLOT_COUNT = 24;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_W     = 5;
    localparam int IVAL_W     = 32;
    localparam int TIME_W     = 64;

    localparam logic [TIME_W-1:0] WAIT_NONE = 64'h0000_0000_FFFF_FFFF;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [2:0] {
        MODE_ALLOC   = 3'd0,
        MODE_START   = 3'd1,
        MODE_STOP    = 3'd2,
        MODE_RESCHED = 3'd3,
        MODE_RELEASE = 3'd4,
        MODE_READ    = 3'd5,
        MODE_SHIFT   = 3'd6,
        MODE_PROCESS = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DONE   = 2'd0,
        KIND_NOSLOT = 2'd1,
        KIND_FIRED  = 2'd2,
        KIND_WAIT   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_UNUSED  = 2'd0,
        ST_RUNNING = 2'd1,
        ST_STOPPED = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARM,
        S_READ,
        S_SH_DIFF,
        S_SH_RD,
        S_SH_WR,
        S_SC_RD,
        S_SC_CMP,
        S_FIRE,
        S_FN_RD,
        S_FN_ADD,
        S_FN_SUB,
        S_FN_CMP,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic              sub;
        logic [TIME_W-1:0] ca;
        logic [TIME_W-1:0] cb;
    } t_alu_req;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              carry;
        logic              lt;
    } t_alu_rsp;

    function automatic t_idx slot_idx(input logic [SLOT_W-1:0] slot);
        return t_idx'(slot);
    endfunction

endpackage

/* rtl/its_ram.sv */
// ---------------------------------------------------------------------------
// its_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module its_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 24
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/its_alu.sv */
// ---------------------------------------------------------------------------
// its_alu
// Shared 64-bit add/subtract unit with carry out and an unsigned comparator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module its_alu (
    input  its_pkg::t_alu_req i_req,
    output its_pkg::t_alu_rsp o_rsp
);

    logic [its_pkg::TIME_W-1:0] b_op;
    logic [its_pkg::TIME_W:0]   full;

    assign b_op = i_req.sub ? ~i_req.b : i_req.b;
    assign full = {1'b0, i_req.a} + {1'b0, b_op} + (its_pkg::TIME_W + 1)'(i_req.sub);

    assign o_rsp.sum   = full[its_pkg::TIME_W-1:0];
    assign o_rsp.carry = full[its_pkg::TIME_W];
    assign o_rsp.lt    = i_req.ca < i_req.cb;

endmodule

/* rtl/interval_timer_slot_table_top.sv */
// ---------------------------------------------------------------------------
// interval_timer_slot_table_top
// Periodic timer slot table driven by one shared 64-bit arithmetic unit.
// ---------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low. Results
// come out one per cycle-long pulse of o_strobe, and o_last marks the final
// result of a request. The receiver cannot stall the block.
// Allocate, stop and release finish in the accept cycle; their result shows
// in the next cycle and busy stays low. Start and reschedule of a used slot
// pass through S_ARM, and read through S_READ; start and read wait there
// for the registered interval read. Shift forms the time difference
// (S_SH_DIFF), then adds it to each used slot's deadline in turn (S_SH_RD, S_SH_WR).
// Process scans every slot (S_SC_RD, S_SC_CMP) once per fired slot, which
// S_FIRE reports, and once more to find none left; then one final pass over
// every slot (S_FN_RD to S_FN_CMP) rearms fired slots and finds the wait.
// These steps run in order on the one shared adder and comparator.
// Reset clears every slot to unused and leaves the block idle; interval and
// deadline memories are not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module interval_timer_slot_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [4:0]  i_slot,
    input  logic [31:0] i_interval,
    input  logic [63:0] i_now_ms,
    input  logic [63:0] i_new_time_ms,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [4:0]  o_slot_out,
    output logic [31:0] o_value,
    output logic        o_last
);

    its_pkg::t_state  r_state;
    its_pkg::t_state  n_state;
    its_pkg::t_status r_status [its_pkg::SLOT_COUNT];
    its_pkg::t_status n_status [its_pkg::SLOT_COUNT];
    logic [its_pkg::SLOT_COUNT-1:0] r_fired;
    logic [its_pkg::SLOT_COUNT-1:0] n_fired;
    logic            r_pick_vld;
    logic            n_pick_vld;
    logic            r_strobe;
    logic            n_strobe;

    its_pkg::t_idx   r_idx;
    its_pkg::t_idx   n_idx;
    its_pkg::t_idx   r_pick;
    its_pkg::t_idx   n_pick;
    its_pkg::t_idx   r_slot;
    its_pkg::t_idx   n_slot;
    its_pkg::t_mode  r_mode;
    its_pkg::t_mode  n_mode;
    logic            r_ok;
    logic            n_ok;
    logic            r_wok;
    logic            n_wok;
    logic [its_pkg::IVAL_W-1:0] r_ival;
    logic [its_pkg::IVAL_W-1:0] n_ival;
    logic [its_pkg::TIME_W-1:0] r_now;
    logic [its_pkg::TIME_W-1:0] n_now;
    logic [its_pkg::TIME_W-1:0] r_new;
    logic [its_pkg::TIME_W-1:0] n_new;
    logic [its_pkg::TIME_W-1:0] r_acc;
    logic [its_pkg::TIME_W-1:0] n_acc;
    logic [its_pkg::TIME_W-1:0] r_best;
    logic [its_pkg::TIME_W-1:0] n_best;

    its_pkg::t_kind  r_kind;
    its_pkg::t_kind  n_kind;
    logic [its_pkg::SLOT_W-1:0] r_slot_out;
    logic [its_pkg::SLOT_W-1:0] n_slot_out;
    logic [its_pkg::IVAL_W-1:0] r_value;
    logic [its_pkg::IVAL_W-1:0] n_value;
    logic            r_last;
    logic            n_last;

    its_pkg::t_alu_req alu_req;
    its_pkg::t_alu_rsp alu_rsp;

    logic                       ival_we;
    its_pkg::t_idx              ival_waddr;
    its_pkg::t_idx              ival_raddr;
    logic [its_pkg::IVAL_W-1:0] ival_rdata;
    logic                       dl_we;
    its_pkg::t_idx              dl_waddr;
    logic [its_pkg::TIME_W-1:0] dl_rdata;

    its_pkg::t_mode in_mode;
    its_pkg::t_idx  in_idx;
    logic           in_ok;
    logic           in_used;
    logic           free_vld;
    its_pkg::t_idx  free_idx;
    logic           idx_last;
    logic           cur_run;
    logic           cur_used;
    logic           sc_hit;

    assign in_mode  = its_pkg::t_mode'(i_mode);
    assign in_idx   = its_pkg::slot_idx(i_slot);
    assign in_ok    = int'(i_slot) < its_pkg::SLOT_COUNT;
    assign in_used  = in_ok && (r_status[in_idx] != its_pkg::ST_UNUSED);
    assign idx_last = r_idx == its_pkg::t_idx'(its_pkg::SLOT_COUNT - 1);
    assign cur_run  = r_status[r_idx] == its_pkg::ST_RUNNING;
    assign cur_used = r_status[r_idx] != its_pkg::ST_UNUSED;
    assign sc_hit   = cur_run && !r_fired[r_idx] && alu_rsp.carry
                      && (!r_pick_vld || alu_rsp.lt);
    assign busy     = r_state != its_pkg::S_IDLE;

    always_comb begin
        free_vld = 1'b0;
        free_idx = '0;
        for (int k = its_pkg::SLOT_COUNT - 1; k >= 0; k--) begin
            if (r_status[k] == its_pkg::ST_UNUSED) begin
                free_vld = 1'b1;
                free_idx = its_pkg::t_idx'(k);
            end
        end
    end

    assign ival_raddr = (r_state == its_pkg::S_IDLE) ? in_idx : r_idx;

    its_ram #(
        .WIDTH(its_pkg::IVAL_W),
        .DEPTH(its_pkg::SLOT_COUNT)
    ) u_ival_ram (
        .i_clk  (i_clk),
        .i_we   (ival_we),
        .i_waddr(ival_waddr),
        .i_wdata(i_interval),
        .i_raddr(ival_raddr),
        .o_rdata(ival_rdata)
    );

    its_ram #(
        .WIDTH(its_pkg::TIME_W),
        .DEPTH(its_pkg::SLOT_COUNT)
    ) u_dl_ram (
        .i_clk  (i_clk),
        .i_we   (dl_we),
        .i_waddr(dl_waddr),
        .i_wdata(alu_rsp.sum),
        .i_raddr(r_idx),
        .o_rdata(dl_rdata)
    );

    its_alu u_alu (
        .i_req(alu_req),
        .o_rsp(alu_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            its_pkg::S_IDLE: begin
                if (start) begin
                    case (in_mode)
                        its_pkg::MODE_START,
                        its_pkg::MODE_RESCHED: n_state = in_used ? its_pkg::S_ARM
                                                                 : its_pkg::S_IDLE;
                        its_pkg::MODE_READ:    n_state = its_pkg::S_READ;
                        its_pkg::MODE_SHIFT:   n_state = its_pkg::S_SH_DIFF;
                        its_pkg::MODE_PROCESS: n_state = its_pkg::S_SC_RD;
                        default:               n_state = its_pkg::S_IDLE;
                    endcase
                end
            end
            its_pkg::S_ARM:     n_state = its_pkg::S_IDLE;
            its_pkg::S_READ:    n_state = its_pkg::S_IDLE;
            its_pkg::S_SH_DIFF: n_state = its_pkg::S_SH_RD;
            its_pkg::S_SH_RD:   n_state = its_pkg::S_SH_WR;
            its_pkg::S_SH_WR:   n_state = idx_last ? its_pkg::S_IDLE : its_pkg::S_SH_RD;
            its_pkg::S_SC_RD:   n_state = its_pkg::S_SC_CMP;
            its_pkg::S_SC_CMP: begin
                if (!idx_last) begin
                    n_state = its_pkg::S_SC_RD;
                end else if (r_pick_vld || sc_hit) begin
                    n_state = its_pkg::S_FIRE;
                end else begin
                    n_state = its_pkg::S_FN_RD;
                end
            end
            its_pkg::S_FIRE:    n_state = its_pkg::S_SC_RD;
            its_pkg::S_FN_RD:   n_state = its_pkg::S_FN_ADD;
            its_pkg::S_FN_ADD:  n_state = its_pkg::S_FN_SUB;
            its_pkg::S_FN_SUB:  n_state = its_pkg::S_FN_CMP;
            its_pkg::S_FN_CMP:  n_state = idx_last ? its_pkg::S_REPORT : its_pkg::S_FN_RD;
            its_pkg::S_REPORT:  n_state = its_pkg::S_IDLE;
            default:            n_state = its_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_status   = r_status;
        n_fired    = r_fired;
        n_pick_vld = r_pick_vld;
        n_idx      = r_idx;
        n_pick     = r_pick;
        n_slot     = r_slot;
        n_mode     = r_mode;
        n_ok       = r_ok;
        n_wok      = r_wok;
        n_ival     = r_ival;
        n_now      = r_now;
        n_new      = r_new;
        n_acc      = r_acc;
        n_best     = r_best;
        n_strobe   = 1'b0;
        n_kind     = its_pkg::KIND_DONE;
        n_slot_out = '0;
        n_value    = '0;
        n_last     = 1'b1;
        alu_req    = '0;
        ival_we    = 1'b0;
        ival_waddr = in_idx;
        dl_we      = 1'b0;
        dl_waddr   = r_idx;
        case (r_state)
            its_pkg::S_IDLE: begin
                if (start) begin
                    n_mode     = in_mode;
                    n_slot     = in_idx;
                    n_ok       = in_ok;
                    n_ival     = i_interval;
                    n_now      = i_now_ms;
                    n_new      = i_new_time_ms;
                    n_idx      = '0;
                    n_pick_vld = 1'b0;
                    case (in_mode)
                        its_pkg::MODE_ALLOC: begin
                            n_strobe = 1'b1;
                            if (free_vld) begin
                                n_status[free_idx] = its_pkg::ST_STOPPED;
                                ival_we    = 1'b1;
                                ival_waddr = free_idx;
                                n_slot_out = its_pkg::SLOT_W'(free_idx);
                            end else begin
                                n_kind = its_pkg::KIND_NOSLOT;
                            end
                        end
                        its_pkg::MODE_START: begin
                            n_strobe = !in_used;
                        end
                        its_pkg::MODE_RESCHED: begin
                            ival_we  = in_used;
                            n_strobe = !in_used;
                        end
                        its_pkg::MODE_STOP: begin
                            if (in_used) begin
                                n_status[in_idx] = its_pkg::ST_STOPPED;
                            end
                            n_strobe = 1'b1;
                        end
                        its_pkg::MODE_RELEASE: begin
                            if (in_ok) begin
                                n_status[in_idx] = its_pkg::ST_UNUSED;
                            end
                            n_strobe = 1'b1;
                        end
                        its_pkg::MODE_PROCESS: begin
                            n_fired = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            its_pkg::S_ARM: begin
                alu_req.a = r_now;
                alu_req.b = (r_mode == its_pkg::MODE_START)
                            ? its_pkg::TIME_W'(ival_rdata) : its_pkg::TIME_W'(r_ival);
                dl_we     = 1'b1;
                dl_waddr  = r_slot;
                n_status[r_slot] = its_pkg::ST_RUNNING;
                n_strobe  = 1'b1;
            end
            its_pkg::S_READ: begin
                n_strobe = 1'b1;
                n_value  = r_ok ? ival_rdata : '0;
            end
            its_pkg::S_SH_DIFF: begin
                alu_req.a   = r_new;
                alu_req.b   = r_now;
                alu_req.sub = 1'b1;
                n_acc       = alu_rsp.sum;
            end
            its_pkg::S_SH_WR: begin
                alu_req.a = dl_rdata;
                alu_req.b = r_acc;
                dl_we     = cur_used;
                if (idx_last) begin
                    n_strobe = 1'b1;
                end else begin
                    n_idx = r_idx + its_pkg::t_idx'(1);
                end
            end
            its_pkg::S_SC_CMP: begin
                alu_req.a   = r_now;
                alu_req.b   = dl_rdata;
                alu_req.sub = 1'b1;
                alu_req.ca  = dl_rdata;
                alu_req.cb  = r_best;
                if (sc_hit) begin
                    n_pick     = r_idx;
                    n_best     = dl_rdata;
                    n_pick_vld = 1'b1;
                end
                if (idx_last) begin
                    n_idx = '0;
                    if (!(r_pick_vld || sc_hit)) begin
                        n_best = its_pkg::WAIT_NONE;
                    end
                end else begin
                    n_idx = r_idx + its_pkg::t_idx'(1);
                end
            end
            its_pkg::S_FIRE: begin
                n_strobe        = 1'b1;
                n_kind          = its_pkg::KIND_FIRED;
                n_slot_out      = its_pkg::SLOT_W'(r_pick);
                n_last          = 1'b0;
                n_fired[r_pick] = 1'b1;
                n_pick_vld      = 1'b0;
            end
            its_pkg::S_FN_ADD: begin
                alu_req.a = r_now;
                alu_req.b = its_pkg::TIME_W'(ival_rdata);
                if (r_fired[r_idx]) begin
                    dl_we = 1'b1;
                    n_acc = alu_rsp.sum;
                end else begin
                    n_acc = dl_rdata;
                end
            end
            its_pkg::S_FN_SUB: begin
                alu_req.a   = r_acc;
                alu_req.b   = r_now;
                alu_req.sub = 1'b1;
                n_acc       = alu_rsp.sum;
                n_wok       = cur_run && alu_rsp.carry && (alu_rsp.sum != '0);
            end
            its_pkg::S_FN_CMP: begin
                alu_req.ca = r_acc;
                alu_req.cb = r_best;
                if (r_wok && alu_rsp.lt) begin
                    n_best = r_acc;
                end
                n_idx = idx_last ? '0 : r_idx + its_pkg::t_idx'(1);
            end
            its_pkg::S_REPORT: begin
                n_strobe = 1'b1;
                n_kind   = its_pkg::KIND_WAIT;
                n_value  = (r_best == its_pkg::WAIT_NONE) ? '0
                                                          : r_best[its_pkg::IVAL_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= its_pkg::S_IDLE;
            r_strobe   <= 1'b0;
            r_fired    <= '0;
            r_pick_vld <= 1'b0;
            r_idx      <= '0;
            r_mode     <= its_pkg::MODE_ALLOC;
            for (int k = 0; k < its_pkg::SLOT_COUNT; k++) begin
                r_status[k] <= its_pkg::ST_UNUSED;
            end
        end else begin
            r_state    <= n_state;
            r_strobe   <= n_strobe;
            r_fired    <= n_fired;
            r_pick_vld <= n_pick_vld;
            r_idx      <= n_idx;
            r_mode     <= n_mode;
            r_status   <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pick     <= n_pick;
        r_slot     <= n_slot;
        r_ok       <= n_ok;
        r_wok      <= n_wok;
        r_ival     <= n_ival;
        r_now      <= n_now;
        r_new      <= n_new;
        r_acc      <= n_acc;
        r_best     <= n_best;
        r_kind     <= n_kind;
        r_slot_out <= n_slot_out;
        r_value    <= n_value;
        r_last     <= n_last;
    end

    assign o_strobe   = r_strobe;
    assign o_kind     = r_kind;
    assign o_slot_out = r_slot_out;
    assign o_value    = r_value;
    assign o_last     = r_last;

endmodule

/* rtl/its_chk.sv */
// ---------------------------------------------------------------------------
// its_chk
// Port-level checks on the interval timer slot table, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module its_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  i_mode,
    input logic        o_strobe,
    input logic [1:0]  o_kind,
    input logic        o_last
);

    logic quick_req;
    logic proc_req;
    logic fired_kind;

    assign quick_req  = start && !busy && (i_mode == its_pkg::MODE_ALLOC
                        || i_mode == its_pkg::MODE_STOP
                        || i_mode == its_pkg::MODE_RELEASE);
    assign proc_req   = start && !busy && (i_mode == its_pkg::MODE_PROCESS);
    assign fired_kind = o_kind == its_pkg::KIND_FIRED;

    `ASSERT_SAME(a_more_keeps_busy, i_clk, i_rst_n, o_strobe && !o_last, busy)
    `ASSERT_SAME(a_fired_not_last, i_clk, i_rst_n, o_strobe, fired_kind == !o_last)
    `ASSERT_NEXT(a_quick_request, i_clk, i_rst_n, quick_req, o_strobe && o_last && !busy)
    `ASSERT_NEXT(a_process_scans, i_clk, i_rst_n, proc_req, busy && !o_strobe)

endmodule

bind interval_timer_slot_table_top its_chk u_its_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_mode  (i_mode),
    .o_strobe(o_strobe),
    .o_kind  (o_kind),
    .o_last  (o_last)
);

/* verif/interval_timer_slot_table_top_tb.sv */
// ---------------------------------------------------------------------------
// interval_timer_slot_table_top_tb
// Self-checking bench for the periodic timer slot table. A table of directed
// requests covers the extremes and corner cases. Random requests follow:
// first the table is filled until allocation fails, then timer operations
// run, mostly on live slots. A behavioral model predicts each result that
// a directed row does not give; each strobed result is compared in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module interval_timer_slot_table_top_tb;

    typedef struct packed {
        its_pkg::t_kind kind;
        logic [4:0]     slot;
        logic [31:0]    value;
        logic           last;
    } t_timer_result;

    typedef struct {
        its_pkg::t_mode mode;
        logic [4:0]     slot;
        logic [31:0]    ival;
        logic [63:0]    now_v;
        logic [63:0]    newt;
        bit             typed;
        t_timer_result  want;
    } t_drill_row;

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          RANDOM_REQS  = 250;
    localparam logic [63:0] MAXT         = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam t_timer_result R_DONE = '{its_pkg::KIND_DONE, 5'd0, 32'd0, 1'b1};
    localparam t_timer_result R_NONE = '{its_pkg::KIND_DONE, 5'd0, 32'd0, 1'b0};

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_mode;
    logic [4:0]  i_slot;
    logic [31:0] i_interval;
    logic [63:0] i_now_ms;
    logic [63:0] i_new_time_ms;
    logic        o_strobe;
    logic [1:0]  o_kind;
    logic [4:0]  o_slot_out;
    logic [31:0] o_value;
    logic        o_last;

    its_pkg::t_status slot_state  [its_pkg::SLOT_COUNT];
    logic [31:0]      slot_period [its_pkg::SLOT_COUNT];
    logic [63:0]      slot_due    [its_pkg::SLOT_COUNT];
    bit               slot_seen   [its_pkg::SLOT_COUNT];
    t_timer_result    step_results[$];
    t_timer_result    pending_results[$];
    t_drill_row       drill [25];
    int               fail_count  = 0;
    int unsigned      cycle_count = 0;
    bit               idle_on;
    logic [63:0]      cur_now;

    interval_timer_slot_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_slot        (i_slot),
        .i_interval    (i_interval),
        .i_now_ms      (i_now_ms),
        .i_new_time_ms (i_new_time_ms),
        .o_strobe      (o_strobe),
        .o_kind        (o_kind),
        .o_slot_out    (o_slot_out),
        .o_value       (o_value),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d slot %0d value %0h last %0d",
                       o_kind, o_slot_out, o_value, o_last);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    fail_count++;
                end
                if (o_slot_out !== want.slot) begin
                    $error("slot_out: expected %0d, got %0d", want.slot, o_slot_out);
                    fail_count++;
                end
                if (o_value !== want.value) begin
                    $error("value: expected %0h, got %0h", want.value, o_value);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    task automatic predict_timer_results(input its_pkg::t_mode m, input logic [4:0] s,
                                         input logic [31:0] ival, input logic [63:0] now_v,
                                         input logic [63:0] newt);
        bit          ok;
        bit          used;
        bit          found;
        bit          fired [its_pkg::SLOT_COUNT];
        int          pick;
        logic [63:0] best;
        logic [63:0] w;
        logic [63:0] diff;
        ok = s < its_pkg::SLOT_COUNT;
        used = ok && slot_state[s] != its_pkg::ST_UNUSED;
        case (m)
            its_pkg::MODE_ALLOC: begin
                found = 1'b0;
                for (int i = 0; i < its_pkg::SLOT_COUNT; i++) begin
                    if (!found && slot_state[i] == its_pkg::ST_UNUSED) begin
                        slot_state[i] = its_pkg::ST_STOPPED;
                        slot_period[i] = ival;
                        slot_seen[i] = 1'b1;
                        step_results.push_back(t_timer_result'{its_pkg::KIND_DONE, 5'(i),
                                                               32'd0, 1'b1});
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    step_results.push_back(t_timer_result'{its_pkg::KIND_NOSLOT, 5'd0,
                                                           32'd0, 1'b1});
                end
            end
            its_pkg::MODE_START, its_pkg::MODE_RESCHED: begin
                if (used) begin
                    if (m == its_pkg::MODE_RESCHED) begin
                        slot_period[s] = ival;
                    end
                    slot_state[s] = its_pkg::ST_RUNNING;
                    slot_due[s] = now_v + 64'(slot_period[s]);
                end
                step_results.push_back(R_DONE);
            end
            its_pkg::MODE_STOP: begin
                if (used) begin
                    slot_state[s] = its_pkg::ST_STOPPED;
                end
                step_results.push_back(R_DONE);
            end
            its_pkg::MODE_RELEASE: begin
                if (ok) begin
                    slot_state[s] = its_pkg::ST_UNUSED;
                end
                step_results.push_back(R_DONE);
            end
            its_pkg::MODE_READ: begin
                step_results.push_back(t_timer_result'{its_pkg::KIND_DONE, 5'd0,
                                       ok ? slot_period[s] : 32'd0, 1'b1});
            end
            its_pkg::MODE_SHIFT: begin
                diff = newt - now_v;
                for (int i = 0; i < its_pkg::SLOT_COUNT; i++) begin
                    if (slot_state[i] != its_pkg::ST_UNUSED) begin
                        slot_due[i] = slot_due[i] + diff;
                    end
                end
                step_results.push_back(R_DONE);
            end
            default: begin
                for (int i = 0; i < its_pkg::SLOT_COUNT; i++) begin
                    fired[i] = 1'b0;
                end
                forever begin
                    pick = -1;
                    for (int i = 0; i < its_pkg::SLOT_COUNT; i++) begin
                        if (slot_state[i] == its_pkg::ST_RUNNING && !fired[i]
                            && slot_due[i] <= now_v) begin
                            if (pick < 0 || slot_due[i] < slot_due[pick]) begin
                                pick = i;
                            end
                        end
                    end
                    if (pick < 0) begin
                        break;
                    end
                    step_results.push_back(t_timer_result'{its_pkg::KIND_FIRED, 5'(pick),
                                                           32'd0, 1'b0});
                    fired[pick] = 1'b1;
                    slot_due[pick] = now_v + 64'(slot_period[pick]);
                end
                best = its_pkg::WAIT_NONE;
                for (int i = 0; i < its_pkg::SLOT_COUNT; i++) begin
                    if (slot_state[i] == its_pkg::ST_RUNNING && slot_due[i] > now_v) begin
                        w = slot_due[i] - now_v;
                        if (w < best) begin
                            best = w;
                        end
                    end
                end
                step_results.push_back(t_timer_result'{its_pkg::KIND_WAIT, 5'd0,
                                       best != its_pkg::WAIT_NONE ? best[31:0] : 32'd0,
                                       1'b1});
            end
        endcase
    endtask

    // Called and returns just after a falling edge; start is left high.
    task automatic issue(input its_pkg::t_mode m, input logic [4:0] s,
                         input logic [31:0] ival, input logic [63:0] now_v,
                         input logic [63:0] newt, input bit typed,
                         input t_timer_result want);
        if (idle_on) begin
            while ($urandom_range(0, 99) < 10) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_mode        <= m;
        i_slot        <= s;
        i_interval    <= ival;
        i_now_ms      <= now_v;
        i_new_time_ms <= newt;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_timer_results(m, s, ival, now_v, newt);
        if (typed) begin
            pending_results.push_back(want);
        end else begin
            foreach (step_results[i]) begin
                pending_results.push_back(step_results[i]);
            end
        end
        step_results.delete();
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [31:0] pick_interval();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3, 4:    return 32'(10 ** $urandom_range(0, 3));
            default: return 32'($urandom_range(1, 3000));
        endcase
    endfunction

    task automatic random_request();
        its_pkg::t_mode m;
        logic [4:0]     s;
        logic [63:0]    newt;
        int             r;
        int             live[$];
        for (int i = 0; i < its_pkg::SLOT_COUNT; i++) begin
            if (slot_state[i] != its_pkg::ST_UNUSED) begin
                live.push_back(i);
            end
        end
        r = $urandom_range(0, 99);
        if (r < 14)      m = its_pkg::MODE_ALLOC;
        else if (r < 30) m = its_pkg::MODE_START;
        else if (r < 38) m = its_pkg::MODE_STOP;
        else if (r < 50) m = its_pkg::MODE_RESCHED;
        else if (r < 58) m = its_pkg::MODE_RELEASE;
        else if (r < 68) m = its_pkg::MODE_READ;
        else if (r < 75) m = its_pkg::MODE_SHIFT;
        else             m = its_pkg::MODE_PROCESS;
        if (live.size() > 0 && $urandom_range(0, 99) < 85) begin
            s = 5'(live[$urandom_range(0, live.size() - 1)]);
        end else begin
            s = 5'($urandom_range(0, 31));
        end
        // A slot that was never allocated holds no defined interval.
        if (m == its_pkg::MODE_READ && s < its_pkg::SLOT_COUNT && !slot_seen[s]) begin
            s = 5'($urandom_range(its_pkg::SLOT_COUNT, 31));
        end
        r = $urandom_range(0, 99);
        if (r < 85)      cur_now = cur_now + 64'($urandom_range(0, 2500));
        else if (r < 93) cur_now = {$urandom, $urandom};
        else             cur_now = MAXT - 64'($urandom_range(0, 3000));
        case ($urandom_range(0, 3))
            0, 1:    newt = cur_now + 64'($urandom_range(0, 5000)) - 64'd2500;
            2:       newt = {$urandom, $urandom};
            default: newt = 64'($urandom_range(0, 3000));
        endcase
        if (m != its_pkg::MODE_SHIFT && $urandom_range(0, 1) == 0) begin
            newt = {$urandom, $urandom};
        end
        issue(m, s, pick_interval(), cur_now, newt, 1'b0, R_NONE);
        if (m == its_pkg::MODE_SHIFT) begin
            cur_now = newt;
        end
    endtask

    initial begin
        int  n_random;
        bit  any_free;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_mode        = its_pkg::MODE_ALLOC;
        i_slot        = 5'd0;
        i_interval    = 32'd0;
        i_now_ms      = 64'd0;
        i_new_time_ms = 64'd0;
        idle_on       = 1'b1;
        cur_now       = 64'd0;
        for (int i = 0; i < its_pkg::SLOT_COUNT; i++) begin
            slot_state[i]  = its_pkg::ST_UNUSED;
            slot_period[i] = 32'd0;
            slot_due[i]    = 64'd0;
            slot_seen[i]   = 1'b0;
        end

        drill[0]  = '{its_pkg::MODE_READ,    5'd31, 32'd0,    64'd0,    64'd0, 1'b1,
                      R_DONE};
        drill[1]  = '{its_pkg::MODE_ALLOC,   5'd0,  32'hFFFF_FFFF, 64'd0, 64'd0, 1'b1,
                      '{its_pkg::KIND_DONE, 5'd0, 32'd0, 1'b1}};
        drill[2]  = '{its_pkg::MODE_ALLOC,   5'd0,  32'd0,    64'd0,    64'd0, 1'b1,
                      '{its_pkg::KIND_DONE, 5'd1, 32'd0, 1'b1}};
        drill[3]  = '{its_pkg::MODE_ALLOC,   5'd0,  32'd1000, 64'd0,    64'd0, 1'b1,
                      '{its_pkg::KIND_DONE, 5'd2, 32'd0, 1'b1}};
        drill[4]  = '{its_pkg::MODE_ALLOC,   5'd0,  32'd100,  64'd0,    64'd0, 1'b1,
                      '{its_pkg::KIND_DONE, 5'd3, 32'd0, 1'b1}};
        drill[5]  = '{its_pkg::MODE_ALLOC,   5'd0,  32'd100,  64'd0,    64'd0, 1'b1,
                      '{its_pkg::KIND_DONE, 5'd4, 32'd0, 1'b1}};
        drill[6]  = '{its_pkg::MODE_READ,    5'd0,  32'd0,    64'd0,    64'd0, 1'b1,
                      '{its_pkg::KIND_DONE, 5'd0, 32'hFFFF_FFFF, 1'b1}};
        drill[7]  = '{its_pkg::MODE_START,   5'd5,  32'd0,    64'd123,  64'd0, 1'b1,
                      R_DONE};
        drill[8]  = '{its_pkg::MODE_START,   5'd0,  32'd0,    64'd0,    64'd0, 1'b1,
                      R_DONE};
        drill[9]  = '{its_pkg::MODE_PROCESS, 5'd0,  32'd0,    64'd0,    64'd0, 1'b1,
                      '{its_pkg::KIND_WAIT, 5'd0, 32'd0, 1'b1}};
        drill[10] = '{its_pkg::MODE_START,   5'd1,  32'd0,    MAXT,     64'd0, 1'b1,
                      R_DONE};
        drill[11] = '{its_pkg::MODE_START,   5'd2,  32'd0,    64'd5,    64'd0, 1'b1,
                      R_DONE};
        drill[12] = '{its_pkg::MODE_START,   5'd4,  32'd0,    64'd905,  64'd0, 1'b1,
                      R_DONE};
        drill[13] = '{its_pkg::MODE_START,   5'd3,  32'd0,    64'd905,  64'd0, 1'b1,
                      R_DONE};
        drill[14] = '{its_pkg::MODE_PROCESS, 5'd0,  32'd0,    64'd1005, 64'd0, 1'b0,
                      R_NONE};
        drill[15] = '{its_pkg::MODE_RESCHED, 5'd1,  32'd0,    64'd10,   64'd0, 1'b1,
                      R_DONE};
        drill[16] = '{its_pkg::MODE_PROCESS, 5'd0,  32'd0,    64'd20,   64'd0, 1'b0,
                      R_NONE};
        drill[17] = '{its_pkg::MODE_SHIFT,   5'd0,  32'd0,    64'd0,    MAXT,  1'b1,
                      R_DONE};
        drill[18] = '{its_pkg::MODE_STOP,    5'd0,  32'd0,    64'd0,    64'd0, 1'b1,
                      R_DONE};
        drill[19] = '{its_pkg::MODE_RESCHED, 5'd30, 32'd7,    64'd1,    64'd0, 1'b1,
                      R_DONE};
        drill[20] = '{its_pkg::MODE_RELEASE, 5'd2,  32'd0,    64'd0,    64'd0, 1'b1,
                      R_DONE};
        drill[21] = '{its_pkg::MODE_READ,    5'd2,  32'd0,    64'd0,    64'd0, 1'b1,
                      '{its_pkg::KIND_DONE, 5'd0, 32'd1000, 1'b1}};
        drill[22] = '{its_pkg::MODE_RELEASE, 5'd7,  32'd0,    64'd0,    64'd0, 1'b1,
                      R_DONE};
        drill[23] = '{its_pkg::MODE_PROCESS, 5'd0,  32'd0,    MAXT,     64'd0, 1'b0,
                      R_NONE};
        drill[24] = '{its_pkg::MODE_SHIFT,   5'd0,  32'd0,    MAXT,     64'd0, 1'b1,
                      R_DONE};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (drill[i]) begin
            issue(drill[i].mode, drill[i].slot, drill[i].ival, drill[i].now_v,
                  drill[i].newt, drill[i].typed, drill[i].want);
        end
        wait_all_results();

        // Fill the table, then push two requests past the point of no free slot.
        n_random = 0;
        any_free = 1'b1;
        while (any_free) begin
            issue(its_pkg::MODE_ALLOC, 5'($urandom_range(0, 31)), pick_interval(),
                  {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, R_NONE);
            n_random++;
            any_free = 1'b0;
            for (int i = 0; i < its_pkg::SLOT_COUNT; i++) begin
                if (slot_state[i] == its_pkg::ST_UNUSED) begin
                    any_free = 1'b1;
                end
            end
        end
        repeat (2) begin
            issue(its_pkg::MODE_ALLOC, 5'd0, pick_interval(), 64'd0, 64'd0, 1'b0, R_NONE);
            n_random++;
        end

        while (n_random < RANDOM_REQS) begin
            if (n_random == 100) begin
                wait_all_results();
            end
            idle_on = !(n_random >= 150 && n_random < 210);
            random_request();
            n_random++;
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
